[hdl/cbp_pkg.sv]
package cbp_pkg;

  localparam int MAX_ADDRESS_BITS = 8;
  localparam int MAX_HISTORY_BITS = 4;
  localparam int IDX_W = MAX_ADDRESS_BITS + MAX_HISTORY_BITS;
  localparam int TABLE_DEPTH = 1 << IDX_W;
  localparam int USED_W = 13;

  localparam logic [1:0] CFG_HISTORY_LENGTH = 2'd0;
  localparam logic [1:0] CFG_ADDRESS_LENGTH = 2'd1;
  localparam logic [1:0] CFG_COUNTER_WIDTH  = 2'd2;

  localparam logic [1:0] WIDTH_TWO_BIT = 2'd2;

  typedef logic [MAX_HISTORY_BITS-1:0] hist_t;
  typedef logic [MAX_ADDRESS_BITS-1:0] addr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } in_t;

  typedef struct packed {
    logic              prediction;
    logic              was_correct;
    logic [31:0]       correct_count;
    logic [31:0]       total_count;
    logic [USED_W-1:0] entries_used;
  } out_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage

[hdl/cbp_ctrl.sv]
module cbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cbp_pkg::status_t  status,
  output cbp_pkg::cmd_t     cmd
);
  import cbp_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (!status.out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.rd = in_valid;
      end
      ST_CALC: cmd.upd = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/cbp_datapath.sv]
module cbp_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [3:0]      cfg_data,
  input  cbp_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cbp_pkg::out_t   out_data,
  input  cbp_pkg::cmd_t   cmd,
  output cbp_pkg::status_t status
);
  import cbp_pkg::*;

  logic [2:0] history_length;
  logic [3:0] address_length;
  logic [1:0] counter_width;

  logic [2:0] mem [TABLE_DEPTH];
  logic [2:0] rd_q;
  idx_t       clr_addr;

  hist_t ghist;
  hist_t hist_q;
  idx_t  idx_q;
  logic  taken_q;

  logic [31:0]       correct_cnt;
  logic [31:0]       total_cnt;
  logic [USED_W-1:0] used_cnt;

  hist_t hmask;
  addr_t amask;
  idx_t  rd_idx;

  logic [1:0] s;
  logic       visited;
  logic       pred;
  logic       ok;
  logic [1:0] s_next;
  logic [31:0]       correct_next;
  logic [31:0]       total_next;
  logic [USED_W-1:0] used_next;
  hist_t ghist_next;

  logic       mem_we;
  idx_t       mem_waddr;
  logic [2:0] mem_wdata;

  function automatic logic [1:0] next_state2(logic [1:0] st, logic t);
    if (t) begin
      return (st == 2'd0) ? 2'd1 : 2'd3;
    end
    return (st == 2'd3) ? 2'd2 : 2'd0;
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_HISTORY_BITS; i++) begin
      hmask[i] = (i < int'(history_length));
    end
    for (int i = 0; i < MAX_ADDRESS_BITS; i++) begin
      amask[i] = (i < int'(address_length));
    end
  end

  assign rd_idx = {in_data.branch_address[MAX_ADDRESS_BITS-1:0] & amask, ghist & hmask};

  always_comb begin
    s = rd_q[1:0];
    visited = rd_q[2];
    if (counter_width == WIDTH_TWO_BIT) begin
      pred = s[1];
      s_next = next_state2(s, taken_q);
    end else begin
      pred = s[0];
      s_next = {1'b0, taken_q};
    end
    ok = (pred == taken_q);
    correct_next = correct_cnt;
    if (ok && correct_cnt != '1) begin
      correct_next = correct_cnt + 32'd1;
    end
    total_next = total_cnt;
    if (total_cnt != '1) begin
      total_next = total_cnt + 32'd1;
    end
    used_next = used_cnt;
    if (!visited && used_cnt != '1) begin
      used_next = used_cnt + USED_W'(1);
    end
    ghist_next = ((hist_q << 1) | hist_t'(taken_q)) & hmask;
  end

  assign mem_we    = cmd.clr || cmd.upd;
  assign mem_waddr = cmd.clr ? clr_addr : idx_q;
  assign mem_wdata = cmd.clr ? 3'd0 : {1'b1, s_next};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      idx_q   <= rd_idx;
      hist_q  <= ghist & hmask;
      taken_q <= in_data.taken;
    end
    if (cmd.upd) begin
      out_data.prediction    <= pred;
      out_data.was_correct   <= ok;
      out_data.correct_count <= correct_next;
      out_data.total_count   <= total_next;
      out_data.entries_used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_length <= 3'd2;
      address_length <= 4'd8;
      counter_width  <= 2'd2;
      clr_addr       <= '0;
      ghist          <= '0;
      correct_cnt    <= '0;
      total_cnt      <= '0;
      used_cnt       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HISTORY_LENGTH: history_length <= cfg_data[2:0];
          CFG_ADDRESS_LENGTH: address_length <= cfg_data;
          CFG_COUNTER_WIDTH:  counter_width  <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_addr <= clr_addr + idx_t'(1);
      end
      if (cmd.upd) begin
        ghist       <= ghist_next;
        correct_cnt <= correct_next;
        total_cnt   <= total_next;
        used_cnt    <= used_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.clr_last = (clr_addr == '1);
  assign status.out_busy = out_valid && !out_ready;

`ifndef NO_ASSERTIONS
  a_upd_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> !(out_valid && !out_ready))
    else $error("result committed while output slot occupied");
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr, cmd.rd, cmd.upd}))
    else $error("conflicting datapath commands");
  a_upd_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |=> out_valid)
    else $error("committed result not presented");
  a_counts_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.correct_count <= out_data.total_count)
    else $error("correct count exceeds total count");
`endif

endmodule

[hdl/correlating_branch_predictor_top.sv]
// result path: the table entry and inputs are registered on the input transfer, then the
// result is registered in the calc state once the output slot is free; no new branch is
// taken until then, as the table is read in the idle state and written in the calc state
// reset: synchronous, clears history, counters and registers to defaults,
// then a clearing pass over all 4096 table entries with in_ready low
module correlating_branch_predictor_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [3:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  cbp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cbp_pkg::out_t out_data
);
  import cbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cbp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
